@@ rtl/pcbq_pkg.sv @@
// Package: shared constants and types of the per-class byte quota ledger.
package pcbq_pkg;

  localparam int NUM_CLASSES_DEF   = 36;
  localparam int BYTE_WIDTH_DEF    = 48;
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int EV_PER_CLASS      = 7;

  typedef enum logic [3:0] {
    OP_SET_LIMIT = 4'd0,
    OP_RESERVE   = 4'd1,
    OP_RELEASE   = 4'd2,
    OP_HIT       = 4'd3,
    OP_MISS      = 4'd4,
    OP_EVICT     = 4'd5,
    OP_PHYS_RD   = 4'd6,
    OP_PHYS_WR   = 4'd7,
    OP_QUERY     = 4'd8
  } op_t;

  // Event counter slots within a class.
  localparam logic [2:0] EV_RES   = 3'd0;
  localparam logic [2:0] EV_REL   = 3'd1;
  localparam logic [2:0] EV_REJ   = 3'd2;
  localparam logic [2:0] EV_ERR   = 3'd3;
  localparam logic [2:0] EV_HIT   = 3'd4;
  localparam logic [2:0] EV_MISS  = 3'd5;
  localparam logic [2:0] EV_EVICT = 3'd6;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  localparam logic [3:0] SEL_PHYS_RD = 4'd7;
  localparam logic [3:0] SEL_PHYS_WR = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

endpackage

@@ rtl/per_class_byte_quota_ledger_core.sv @@
// Top level: per-class byte quota ledger with memory-held class state.
//
//  channel | dir | tdata fields (low bit up)                        | tuser
//  s_axis  | in  | op[3:0] class_index[9:4] amount[57:10], pad to 64 | -
//  m_axis  | out | class_current, class_peak, class_limit,          | status
//          |     | counter_value, total_current, total_peak,        |
//          |     | within_limits, books_clean, pad to 312           |
//
// An item is accepted in idle and its class rows are read on that edge; the
// next cycle modifies and writes them back and loads the output register.
// The result is offered from S_OUT on; the next item is taken only after the
// result leaves, and a receiver stall holds the block with its result until
// tready returns. After reset a clearing pass sweeps every class row of the
// memories; no item is accepted until it ends.
module per_class_byte_quota_ledger_core #(
  parameter int NUM_CLASSES   = pcbq_pkg::NUM_CLASSES_DEF,
  parameter int BYTE_WIDTH    = pcbq_pkg::BYTE_WIDTH_DEF,
  parameter int COUNTER_WIDTH = pcbq_pkg::COUNTER_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // op[3:0], class_index[9:4], amount[57:10]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [311:0] m_axis_tdata,   // current, peak, limit, counter, totals, flags
  output logic [1:0]   m_axis_tuser    // status
);

  localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int EVW = pcbq_pkg::EV_PER_CLASS * COUNTER_WIDTH;
  localparam int VCW = $clog2(NUM_CLASSES + 1);
  localparam logic [BYTE_WIDTH-1:0] BMAX = '1;

  // Class memories: one row per class.
  logic [BYTE_WIDTH-1:0] lim_mem [NUM_CLASSES];
  logic [BYTE_WIDTH-1:0] cur_mem [NUM_CLASSES];
  logic [BYTE_WIDTH-1:0] pk_mem  [NUM_CLASSES];
  logic [EVW-1:0]        ev_mem  [NUM_CLASSES];
  logic [127:0]          ph_mem  [NUM_CLASSES];

  pcbq_pkg::state_t state, state_next;
  logic [CW-1:0]  clr_idx;
  logic           clearing;
  logic [3:0]     op_r;
  logic [CW-1:0]  cls;
  logic [47:0]    amt_r;

  logic [BYTE_WIDTH-1:0] lim_q, cur_q, pk_q;
  logic [EVW-1:0]        ev_q;
  logic [127:0]          ph_q;

  logic [BYTE_WIDTH-1:0] sum_cur, sum_pk;
  logic [NUM_CLASSES-1:0] viol;
  logic [VCW-1:0]        vcount;
  logic                  err_seen;

  logic [5:0]  in_idx;
  logic [CW-1:0] in_cls;
  logic        accept;

  assign in_idx = s_axis_tdata[9:4];
  assign in_cls = (32'(in_idx) < NUM_CLASSES) ? in_idx[CW-1:0] : '0;
  assign s_axis_tready = (state == pcbq_pkg::S_IDLE) && !clearing;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pcbq_pkg::S_IDLE: if (accept) state_next = pcbq_pkg::S_EXEC;
      pcbq_pkg::S_EXEC: state_next = pcbq_pkg::S_OUT;
      pcbq_pkg::S_OUT:  if (m_axis_tready) state_next = pcbq_pkg::S_IDLE;
      default:          state_next = pcbq_pkg::S_IDLE;
    endcase
  end

  // Output valid.
  always_comb begin
    m_axis_tvalid = (state == pcbq_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pcbq_pkg::S_IDLE;
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        if (32'(clr_idx) == NUM_CLASSES - 1) clearing <= 1'b0;
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Latch the item and read its class rows.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= s_axis_tdata[3:0];
      cls   <= in_cls;
      amt_r <= s_axis_tdata[57:10];
      lim_q <= lim_mem[in_cls];
      cur_q <= cur_mem[in_cls];
      pk_q  <= pk_mem[in_cls];
      ev_q  <= ev_mem[in_cls];
      ph_q  <= ph_mem[in_cls];
    end
  end

  // Modify step.
  logic [BYTE_WIDTH-1:0] amt_b, lim_n, cur_n, pk_n, sc_n, sp_n;
  logic [EVW-1:0]        ev_n;
  logic [127:0]          ph_n;
  logic [63:0]           cnt;
  logic [1:0]            st;
  logic                  err_n, v_new, touch;
  logic [64:0]           ph_sum;

  function automatic logic [EVW-1:0] bump(input logic [EVW-1:0] e, input logic [2:0] w);
    logic [EVW-1:0] r;
    r = e;
    r[32'(w)*COUNTER_WIDTH +: COUNTER_WIDTH] =
      e[32'(w)*COUNTER_WIDTH +: COUNTER_WIDTH] + 1'b1;
    return r;
  endfunction

  always_comb begin
    amt_b = (BYTE_WIDTH >= 48) ? BYTE_WIDTH'(amt_r)
          : ((amt_r > 48'(BMAX)) ? BMAX : amt_r[BYTE_WIDTH-1:0]);
    lim_n = lim_q; cur_n = cur_q; pk_n = pk_q;
    ev_n = ev_q; ph_n = ph_q; sc_n = sum_cur; sp_n = sum_pk;
    err_n = err_seen; cnt = '0; st = pcbq_pkg::ST_DONE; touch = 1'b0;
    ph_sum = '0;
    case (op_r)
      pcbq_pkg::OP_SET_LIMIT: begin
        lim_n = amt_b; touch = 1'b1;
      end
      pcbq_pkg::OP_RESERVE: begin
        touch = 1'b1;
        if (64'(amt_r) > 64'(lim_q) || cur_q > lim_q - amt_b ||
            64'(amt_r) > 64'(BMAX - sum_cur)) begin
          ev_n = bump(ev_q, pcbq_pkg::EV_REJ); st = pcbq_pkg::ST_REJECT;
        end else begin
          cur_n = cur_q + amt_b;
          if (cur_n > pk_q) pk_n = cur_n;
          ev_n = bump(ev_q, pcbq_pkg::EV_RES);
          sc_n = sum_cur + amt_b;
          if (sc_n > sum_pk) sp_n = sc_n;
        end
      end
      pcbq_pkg::OP_RELEASE: begin
        touch = 1'b1;
        ev_n = bump(ev_q, pcbq_pkg::EV_REL);
        if (64'(amt_r) > 64'(cur_q) || 64'(amt_r) > 64'(sum_cur)) begin
          ev_n = bump(ev_n, pcbq_pkg::EV_ERR);
          err_n = 1'b1;
          sc_n = sum_cur - ((cur_q < sum_cur) ? cur_q : sum_cur);
          cur_n = '0; st = pcbq_pkg::ST_ERROR;
        end else begin
          cur_n = cur_q - amt_b; sc_n = sum_cur - amt_b;
        end
      end
      pcbq_pkg::OP_HIT:   ev_n = bump(ev_q, pcbq_pkg::EV_HIT);
      pcbq_pkg::OP_MISS:  ev_n = bump(ev_q, pcbq_pkg::EV_MISS);
      pcbq_pkg::OP_EVICT: ev_n = bump(ev_q, pcbq_pkg::EV_EVICT);
      pcbq_pkg::OP_PHYS_RD: begin
        ph_sum = {1'b0, ph_q[63:0]} + 65'(amt_r);
        ph_n[63:0] = ph_sum[64] ? '1 : ph_sum[63:0];
      end
      pcbq_pkg::OP_PHYS_WR: begin
        ph_sum = {1'b0, ph_q[127:64]} + 65'(amt_r);
        ph_n[127:64] = ph_sum[64] ? '1 : ph_sum[63:0];
      end
      pcbq_pkg::OP_QUERY: begin
        if (amt_r < 48'(pcbq_pkg::EV_PER_CLASS))
          cnt = 64'(ev_q[32'(amt_r[2:0])*COUNTER_WIDTH +: COUNTER_WIDTH]);
        else if (amt_r == 48'(pcbq_pkg::SEL_PHYS_RD)) cnt = ph_q[63:0];
        else if (amt_r == 48'(pcbq_pkg::SEL_PHYS_WR)) cnt = ph_q[127:64];
      end
      default: ;
    endcase
    v_new = (cur_n > lim_n) || (pk_n > lim_n);
  end

  // Write back and register the result.
  always_ff @(posedge clk) begin
    if (clearing) begin
      lim_mem[clr_idx] <= '1;
      cur_mem[clr_idx] <= '0;
      pk_mem[clr_idx]  <= '0;
      ev_mem[clr_idx]  <= '0;
      ph_mem[clr_idx]  <= '0;
    end else if (state == pcbq_pkg::S_EXEC) begin
      lim_mem[cls] <= lim_n;
      cur_mem[cls] <= cur_n;
      pk_mem[cls]  <= pk_n;
      ev_mem[cls]  <= ev_n;
      ph_mem[cls]  <= ph_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_cur <= '0; sum_pk <= '0; viol <= '0; vcount <= '0; err_seen <= 1'b0;
    end else if (state == pcbq_pkg::S_EXEC) begin
      sum_cur <= sc_n; sum_pk <= sp_n; err_seen <= err_n;
      if (touch) begin
        viol[cls] <= v_new;
        if (v_new && !viol[cls]) vcount <= vcount + 1'b1;
        else if (!v_new && viol[cls]) vcount <= vcount - 1'b1;
      end
    end
  end

  logic [1:0]  o_st;
  logic [47:0] o_cur, o_pk, o_lim, o_sc, o_sp;
  logic [63:0] o_cnt;
  logic        o_err;

  always_ff @(posedge clk) begin
    if (state == pcbq_pkg::S_EXEC) begin
      o_st  <= st;
      o_cur <= 48'(cur_n); o_pk <= 48'(pk_n); o_lim <= 48'(lim_n);
      o_cnt <= cnt;
      o_sc  <= 48'(sc_n);  o_sp <= 48'(sp_n);
      o_err <= err_n;
    end
  end

  // Violator count is read after its update settles in S_OUT.
  assign m_axis_tuser = o_st;
  assign m_axis_tdata = {6'd0, ~o_err, (vcount == '0), o_sp, o_sc, o_cnt,
                         o_lim, o_pk, o_cur};

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != pcbq_pkg::S_IDLE |-> !s_axis_tready) else $error("accept while busy");
  a_exec_to_out: assert property (@(posedge clk) disable iff (rst)
    state == pcbq_pkg::S_EXEC |=> m_axis_tvalid) else $error("result missing");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept) else $error("accept during clear");
  a_vcount: assert property (@(posedge clk) disable iff (rst)
    32'(vcount) == $countones(viol)) else $error("violator count mismatch");

endmodule
